// ----- rtl/spc_pkg.sv -----
// ----------------------------------------------------------------------------
// spc_pkg: shared types and constants for the segment proximity clipper
// Widths of the fixed-point datapath, clip limit modes and port layouts.
// ----------------------------------------------------------------------------
package spc_pkg;

  // datapath widths
  localparam int CoordW = 32;        // Q16.16 input coordinate
  localparam int DiffW  = 33;        // difference of two coordinates
  localparam int ProdW  = 66;        // product of two differences
  localparam int DotW   = 67;        // sum of two products
  localparam int SqW    = 68;        // square-root radicand, even width
  localparam int LenW   = 34;        // square-root result
  localparam int ThrW   = 31;        // threshold register
  localparam int TlW    = 65;        // threshold times length
  localparam int DistW  = 70;        // signed limit distance / divider operands
  localparam int RngW   = 17;        // Q1.16 range value

  localparam int SqrtSteps = SqW / 2;
  localparam int DivSteps  = RngW;
  // c0..c2, root, tl, distance, setup, divider, combine
  localparam int ClipLat   = 3 + SqrtSteps + 3 + DivSteps + 1;

  localparam int InDataW  = 8 * CoordW;
  localparam int OutDataW = 72;

  localparam logic [RngW-1:0] ONE_Q16    = 17'h10000;
  localparam logic [ThrW-1:0] THR_RESET  = 31'd6554;

  // outcome of one box limit for a segment
  typedef enum logic [1:0] {
    LIM_NONE,
    LIM_EMPTY,
    LIM_END,
    LIM_START
  } lim_mode_t;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t y;
    coord_t x;
  } pt_t;

  typedef struct packed {
    pt_t p1;
    pt_t p0;
  } seg_t;

  // kept parameter interval
  typedef struct packed {
    logic [RngW-1:0] hi;
    logic [RngW-1:0] lo;
  } rng_t;

  typedef struct packed {
    logic [1:0] pad;
    logic       degenerate;
    logic       is_close;
    rng_t       r2;
    rng_t       r1;
  } out_t;

endpackage

// ----- rtl/spc_delay.sv -----
// ----------------------------------------------------------------------------
// spc_delay: enabled shift line
// Holds a payload for a fixed number of pipeline advances.
// ----------------------------------------------------------------------------
module spc_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sh_r [D];

  // shift on every pipeline advance
  always_ff @(posedge clk) begin
    if (en) begin
      sh_r[0] <= d;
      for (int i = 1; i < D; i++) begin
        sh_r[i] <= sh_r[i-1];
      end
    end
  end

  assign q = sh_r[D-1];

endmodule

// ----- rtl/spc_sqrt.sv -----
// ----------------------------------------------------------------------------
// spc_sqrt: pipelined integer square root
// Digit-by-digit restoring root, one result bit per stage.
// ----------------------------------------------------------------------------
module spc_sqrt (
  input  logic                      clk,
  input  logic                      en,
  input  logic [spc_pkg::SqW-1:0]   sq_in,
  output logic [spc_pkg::LenW-1:0]  root
);
  import spc_pkg::*;

  logic [LenW+3:0] rem_r  [SqrtSteps];
  logic [LenW-1:0] root_r [SqrtSteps];
  logic [SqW-1:0]  s_r    [SqrtSteps];

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_step
    logic [LenW+3:0] rem_in, rem_sh, trial, rem_nxt;
    logic [LenW-1:0] root_in, root_nxt;
    logic [SqW-1:0]  s_in;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign s_in    = sq_in;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign s_in    = s_r[i-1];
    end

    // bring down two radicand bits, try root*4+1
    always_comb begin
      rem_sh = {rem_in[LenW+1:0], s_in[SqW-1 -: 2]};
      trial  = {2'b00, root_in, 2'b01};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_in[LenW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_in[LenW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[i] <= root_nxt;
      end
    end

    if (i < SqrtSteps - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= rem_nxt;
          s_r[i]   <= {s_in[SqW-3:0], 2'b00};
        end
      end
    end
  end

  assign root = root_r[SqrtSteps-1];

endmodule

// ----- rtl/spc_div.sv -----
// ----------------------------------------------------------------------------
// spc_div: pipelined Q1.16 ratio
// floor(65536 * num / den) for num <= den, one quotient bit per stage.
// ----------------------------------------------------------------------------
module spc_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [spc_pkg::DistW-1:0] num,
  input  logic [spc_pkg::DistW-1:0] den,
  output logic [spc_pkg::RngW-1:0]  quo
);
  import spc_pkg::*;

  logic [DistW-1:0] rem_r [DivSteps];
  logic [DistW-1:0] den_r [DivSteps];
  logic [RngW-1:0]  q_r   [DivSteps];

  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    logic [DistW:0]   rem_sh, diff;
    logic [DistW-1:0] den_in, rem_nxt;
    logic [RngW-1:0]  q_in, q_nxt;

    if (i == 0) begin : g_first
      assign rem_sh = {1'b0, num};
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_sh = {rem_r[i-1], 1'b0};
      assign den_in = den_r[i-1];
      assign q_in   = q_r[i-1];
    end

    // restoring subtract
    always_comb begin
      diff = rem_sh - {1'b0, den_in};
      if (rem_sh >= {1'b0, den_in}) begin
        rem_nxt = diff[DistW-1:0];
        q_nxt   = {q_in[RngW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DistW-1:0];
        q_nxt   = {q_in[RngW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i] <= q_nxt;
      end
    end

    if (i < DivSteps - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= rem_nxt;
          den_r[i] <= den_in;
        end
      end
    end
  end

  assign quo = q_r[DivSteps-1];

endmodule

// ----- rtl/spc_clip.sv -----
// ----------------------------------------------------------------------------
// spc_clip: clip one segment against the box around another
// Dot products, box length, limit distances, crossing ratios, interval merge.
// ----------------------------------------------------------------------------
module spc_clip (
  input  logic                     clk,
  input  logic                     en,
  input  logic [spc_pkg::ThrW-1:0] thr,
  input  spc_pkg::seg_t            box,
  input  spc_pkg::seg_t            seg,
  output spc_pkg::rng_t            rng
);
  import spc_pkg::*;

  localparam int DotPackW = 6 * DotW;

  logic signed [DiffW-1:0] ux_r, uy_r;
  logic signed [DiffW-1:0] dx1_r [2], dy1_r [2], dx0_r [2], dy0_r [2];
  logic signed [ProdW-1:0] uxx_r, uyy_r;
  logic signed [ProdW-1:0] m_ex_r [2], m_ey_r [2], m_sx_r [2], m_sy_r [2];
  logic signed [ProdW-1:0] m_vx_r [2], m_vy_r [2];
  logic [ProdW-1:0]        sq_r;
  logic signed [DotW-1:0]  de_r [2], ds_r [2], dv_r [2];
  logic signed [DotW-1:0]  de_d [2], ds_d [2], dv_d [2];
  logic [DotPackW-1:0]     dot_pack, dot_del;
  logic [LenW-1:0]         len;
  logic [TlW-1:0]          tl_r;
  logic signed [DistW-1:0] tl_ext;
  logic signed [DistW-1:0] dist_r [4][2];
  lim_mode_t               mode_r [4];
  logic [DistW-1:0]        num_r [4], den_r [4];
  logic [7:0]              mode_pack, mode_del;
  logic [RngW-1:0]         quo [4];
  rng_t                    rng_nxt, rng_r;
  pt_t                     pts [2];

  assign pts[0] = seg.p0;
  assign pts[1] = seg.p1;

  // c0: box direction and offsets of both points
  always_ff @(posedge clk) begin
    if (en) begin
      ux_r <= DiffW'(box.p1.x) - DiffW'(box.p0.x);
      uy_r <= DiffW'(box.p1.y) - DiffW'(box.p0.y);
      for (int j = 0; j < 2; j++) begin
        dx1_r[j] <= DiffW'(pts[j].x) - DiffW'(box.p1.x);
        dy1_r[j] <= DiffW'(pts[j].y) - DiffW'(box.p1.y);
        dx0_r[j] <= DiffW'(pts[j].x) - DiffW'(box.p0.x);
        dy0_r[j] <= DiffW'(pts[j].y) - DiffW'(box.p0.y);
      end
    end
  end

  // c1: products
  always_ff @(posedge clk) begin
    if (en) begin
      uxx_r <= ProdW'(ux_r) * ProdW'(ux_r);
      uyy_r <= ProdW'(uy_r) * ProdW'(uy_r);
      for (int j = 0; j < 2; j++) begin
        m_ex_r[j] <= ProdW'(dx1_r[j]) * ProdW'(ux_r);
        m_ey_r[j] <= ProdW'(dy1_r[j]) * ProdW'(uy_r);
        m_sx_r[j] <= ProdW'(dx0_r[j]) * ProdW'(ux_r);
        m_sy_r[j] <= ProdW'(dy0_r[j]) * ProdW'(uy_r);
        m_vx_r[j] <= ProdW'(dx0_r[j]) * ProdW'(uy_r);
        m_vy_r[j] <= ProdW'(dy0_r[j]) * ProdW'(ux_r);
      end
    end
  end

  // c2: squared length and dot products
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= uxx_r[ProdW-1:0] + uyy_r[ProdW-1:0];
      for (int j = 0; j < 2; j++) begin
        de_r[j] <= DotW'(m_ex_r[j]) + DotW'(m_ey_r[j]);
        ds_r[j] <= DotW'(m_sx_r[j]) + DotW'(m_sy_r[j]);
        dv_r[j] <= DotW'(m_vy_r[j]) - DotW'(m_vx_r[j]);
      end
    end
  end

  // dot products wait for the length
  assign dot_pack = {dv_r[1], dv_r[0], ds_r[1], ds_r[0], de_r[1], de_r[0]};
  assign {dv_d[1], dv_d[0], ds_d[1], ds_d[0], de_d[1], de_d[0]} = dot_del;

  spc_delay #(.W(DotPackW), .D(SqrtSteps + 1)) u_dot_dly (
    .clk (clk),
    .en  (en),
    .d   (dot_pack),
    .q   (dot_del)
  );

  spc_sqrt u_sqrt (
    .clk   (clk),
    .en    (en),
    .sq_in ({2'b00, sq_r}),
    .root  (len)
  );

  // margin scaled by box length
  always_ff @(posedge clk) begin
    if (en) begin
      tl_r <= TlW'(thr) * TlW'(len);
    end
  end

  assign tl_ext = $signed({{(DistW-TlW){1'b0}}, tl_r});

  // signed distances to end, start and both side limits
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 2; j++) begin
        dist_r[0][j] <= DistW'(de_d[j]) - tl_ext;
        dist_r[1][j] <= -DistW'(ds_d[j]) - tl_ext;
        dist_r[2][j] <= DistW'(dv_d[j]) - tl_ext;
        dist_r[3][j] <= -DistW'(dv_d[j]) - tl_ext;
      end
    end
  end

  // classify each limit and set up its crossing ratio
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        logic pa, pb;
        pa = !dist_r[k][0][DistW-1] && (dist_r[k][0] != '0);
        pb = !dist_r[k][1][DistW-1] && (dist_r[k][1] != '0);
        num_r[k] <= '0;
        den_r[k] <= '0;
        if (pa && pb) begin
          mode_r[k] <= LIM_EMPTY;
        end else if (pb) begin
          mode_r[k] <= LIM_END;
          num_r[k]  <= -dist_r[k][0];
          den_r[k]  <= dist_r[k][1] - dist_r[k][0];
        end else if (pa) begin
          mode_r[k] <= LIM_START;
          num_r[k]  <= dist_r[k][0];
          den_r[k]  <= dist_r[k][0] - dist_r[k][1];
        end else begin
          mode_r[k] <= LIM_NONE;
        end
      end
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_div
    spc_div u_div (
      .clk (clk),
      .en  (en),
      .num (num_r[k]),
      .den (den_r[k]),
      .quo (quo[k])
    );
  end

  assign mode_pack = {mode_r[3], mode_r[2], mode_r[1], mode_r[0]};

  spc_delay #(.W(8), .D(DivSteps)) u_mode_dly (
    .clk (clk),
    .en  (en),
    .d   (mode_pack),
    .q   (mode_del)
  );

  // merge: an empty limit wins, else tightest start and end
  always_comb begin
    logic emp;
    emp        = 1'b0;
    rng_nxt.lo = '0;
    rng_nxt.hi = ONE_Q16;
    for (int k = 0; k < 4; k++) begin
      unique case (lim_mode_t'(mode_del[2*k +: 2]))
        LIM_EMPTY: emp = 1'b1;
        LIM_END:   if (quo[k] < rng_nxt.hi) rng_nxt.hi = quo[k];
        LIM_START: if (quo[k] > rng_nxt.lo) rng_nxt.lo = quo[k];
        default:   ;
      endcase
    end
    if (emp) begin
      rng_nxt.lo = ONE_Q16;
      rng_nxt.hi = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rng_r <= rng_nxt;
    end
  end

  assign rng = rng_r;

endmodule

// ----- rtl/segment_proximity_clip.sv -----
// ----------------------------------------------------------------------------
// segment_proximity_clip: mutual oriented-box clipping of two segments
// Each segment is clipped against a thresholded box around the other one.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | in_tdata: two segments, Q16.16
//  out_    | out | out_tvalid/tready  | out_tdata: two ranges + flags
//  cfg_    | in  | cfg_wr_en          | cfg_wr_data: proximity threshold
//
//  One transaction per cycle unless an untaken result holds the pipe; the data passes the 34-stage
//  square root followed by the 17-stage ratio divider.
//  Reset clears the valid bits and loads the threshold with 6554.
//  The whole pipe advances together; it holds while a result is not taken.
// ----------------------------------------------------------------------------
module segment_proximity_clip (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
  // seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y (32 bits each)
  input  logic [spc_pkg::InDataW-1:0]  in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // range1_start, range1_end, range2_start, range2_end (17 bits each),
  // is_close, degenerate, 2 zero bits
  output logic [spc_pkg::OutDataW-1:0] out_tdata,
  input  logic                         cfg_wr_en,
  input  logic [spc_pkg::ThrW-1:0]     cfg_wr_data
);
  import spc_pkg::*;

  logic            en;
  logic [ThrW-1:0] thr_r;
  seg_t            seg1, seg2;
  logic            deg_in, deg_del;
  logic            vld_r [ClipLat];
  rng_t            r1, r2;
  out_t            out_nxt, out_r;
  logic            out_valid_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  assign seg1 = in_tdata[4*CoordW-1:0];
  assign seg2 = in_tdata[8*CoordW-1:4*CoordW];

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ClipLat; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int i = 1; i < ClipLat; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // zero-length check
  assign deg_in = (seg1.p0 == seg1.p1) || (seg2.p0 == seg2.p1);

  spc_delay #(.W(1), .D(ClipLat)) u_deg_dly (
    .clk (clk),
    .en  (en),
    .d   (deg_in),
    .q   (deg_del)
  );

  spc_clip u_clip1 (
    .clk (clk),
    .en  (en),
    .thr (thr_r),
    .box (seg2),
    .seg (seg1),
    .rng (r1)
  );

  spc_clip u_clip2 (
    .clk (clk),
    .en  (en),
    .thr (thr_r),
    .box (seg1),
    .seg (seg2),
    .rng (r2)
  );

  // final result assembly
  always_comb begin
    out_nxt.pad        = '0;
    out_nxt.degenerate = deg_del;
    if (deg_del) begin
      out_nxt.is_close = 1'b0;
      out_nxt.r1.lo    = ONE_Q16;
      out_nxt.r1.hi    = '0;
      out_nxt.r2.lo    = ONE_Q16;
      out_nxt.r2.hi    = '0;
    end else begin
      out_nxt.is_close = (r1.lo <= r1.hi) && (r2.lo <= r2.hi);
      out_nxt.r1       = r1;
      out_nxt.r2       = r2;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[ClipLat-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

endmodule

// ----- rtl/spc_checker.sv -----
// ----------------------------------------------------------------------------
// spc_checker: port-level checks for segment_proximity_clip
// Watches the stream ports and the result encoding.
// ----------------------------------------------------------------------------
module spc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [spc_pkg::OutDataW-1:0] out_tdata
);
  import spc_pkg::*;

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // input side stalls only behind an untaken result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  // zero-length segments report empty ranges and not close
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[69] |->
      !out_tdata[68] && out_tdata[16:0] == ONE_Q16 && out_tdata[33:17] == '0
      && out_tdata[50:34] == ONE_Q16 && out_tdata[67:51] == '0)
    else $error("degenerate result malformed");

  // a close result has both ranges non-empty and within [0,1]
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[68] |->
      out_tdata[16:0] <= out_tdata[33:17] && out_tdata[50:34] <= out_tdata[67:51]
      && out_tdata[33:17] <= ONE_Q16 && out_tdata[67:51] <= ONE_Q16)
    else $error("close flag disagrees with ranges");

  // reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind segment_proximity_clip spc_checker u_spc_checker (.*);
